FILE: design/assert_macros.svh
// Assertion macros shared by the table RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

FILE: design/lkvt_pkg.sv
// Package for the linear key/value table: sizes, codes, item and
// control/status struct types. No dependencies.
package lkvt_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_DUPLICATE = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [4:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic    cap;
    logic    scan_en;
    logic    hit_cap;
    logic    found_cap;
    logic    rd_last;
    logic    wr_ins;
    logic    wr_mov;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_set;
    status_e st_val;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    logic       match;
    logic       scan_done;
    logic       full;
    logic       out_free;
    logic [1:0] cmd;
  } stat_t;

endpackage

FILE: design/lkvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lkvt_dp.sv
// Datapath of the key/value table: key and value RAMs, scan counter,
// compare stage, entry count and output register. Uses lkvt_pkg, lkvt_ram.
`include "assert_macros.svh"
module lkvt_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkvt_pkg::in_item_t  in_item_i,
  output lkvt_pkg::out_item_t out_item_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  lkvt_pkg::ctl_t      ctl_i,
  output lkvt_pkg::stat_t     stat_o
);

  logic [1:0]        cmd_q;
  lkvt_pkg::key_t    key_q;
  lkvt_pkg::val_t    val_q;
  lkvt_pkg::cnt_t    count_q, scan_q;
  logic              cmp_vld_q;
  lkvt_pkg::idx_t    cmp_idx_q, slot_q;
  lkvt_pkg::val_t    found_q;
  lkvt_pkg::status_e status_q;
  lkvt_pkg::out_item_t out_q;
  logic              out_valid_q;

  logic           more, issue, rd_en, wr_en;
  lkvt_pkg::idx_t rd_addr, wr_addr, last_idx;
  lkvt_pkg::key_t key_rd, key_wr;
  lkvt_pkg::val_t val_rd, val_wr;

  assign more     = scan_q < count_q;
  assign issue    = ctl_i.scan_en && more;
  assign last_idx = lkvt_pkg::idx_t'(count_q - lkvt_pkg::cnt_t'(1));
  assign rd_en    = issue || ctl_i.rd_last;
  assign rd_addr  = ctl_i.rd_last ? last_idx : scan_q[lkvt_pkg::IDX_W-1:0];
  assign wr_en    = ctl_i.wr_ins || ctl_i.wr_mov;
  assign wr_addr  = ctl_i.wr_ins ? count_q[lkvt_pkg::IDX_W-1:0] : slot_q;
  assign key_wr   = ctl_i.wr_ins ? key_q : key_rd;
  assign val_wr   = ctl_i.wr_ins ? val_q : val_rd;

  lkvt_ram #(.WIDTH(lkvt_pkg::KEY_BITS), .DEPTH(lkvt_pkg::ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (key_wr),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (key_rd)
  );

  lkvt_ram #(.WIDTH(lkvt_pkg::VALUE_BITS), .DEPTH(lkvt_pkg::ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (val_wr),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (val_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.cap) begin
        scan_q <= '0;
      end else if (issue) begin
        scan_q <= scan_q + lkvt_pkg::cnt_t'(1);
      end
      cmp_vld_q <= issue;
      if (ctl_i.cnt_inc) begin
        count_q <= count_q + lkvt_pkg::cnt_t'(1);
      end else if (ctl_i.cnt_dec) begin
        count_q <= count_q - lkvt_pkg::cnt_t'(1);
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      cmd_q   <= in_item_i.command;
      key_q   <= lkvt_pkg::key_t'(in_item_i.key);
      val_q   <= lkvt_pkg::val_t'(in_item_i.value);
      found_q <= '0;
    end else if (ctl_i.found_cap) begin
      found_q <= val_rd;
    end
    cmp_idx_q <= scan_q[lkvt_pkg::IDX_W-1:0];
    if (ctl_i.hit_cap) begin
      slot_q <= cmp_idx_q;
    end
    if (ctl_i.st_set) begin
      status_q <= ctl_i.st_val;
    end
    if (ctl_i.out_load) begin
      out_q.status      <= status_q;
      out_q.found_value <= 32'(found_q);
      out_q.entry_count <= 5'(count_q);
    end
  end

  assign stat_o.match     = cmp_vld_q && (key_rd == key_q);
  assign stat_o.scan_done = !cmp_vld_q && !more;
  assign stat_o.full      = count_q >= lkvt_pkg::cnt_t'(lkvt_pkg::ENTRIES);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign stat_o.cmd       = cmd_q;

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

  `ASSERT_NEVER(a_count_range, count_q > lkvt_pkg::cnt_t'(lkvt_pkg::ENTRIES), "count overflow")
  `ASSERT_CLK(a_ins_not_full, ctl_i.wr_ins |-> !stat_o.full && ctl_i.cnt_inc, "insert when full")
  `ASSERT_CLK(a_mov_after_rd, ctl_i.wr_mov |-> $past(ctl_i.rd_last), "move without last read")
  `ASSERT_CLK(a_load_free, ctl_i.out_load |-> stat_o.out_free, "result overwritten")

endmodule

FILE: design/lkvt_ctrl.sv
// Controller of the key/value table: sequences capture, scan, insert,
// last-entry move and result hand-off. Uses lkvt_pkg.
module lkvt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_cmd_i,
  output logic            in_stall_o,
  input  lkvt_pkg::stat_t stat_i,
  output lkvt_pkg::ctl_t  ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MV_RD,
    S_MV_WR,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.cap = 1'b1;
          if (in_cmd_i == lkvt_pkg::CMD_INSERT || in_cmd_i == lkvt_pkg::CMD_LOOKUP ||
              in_cmd_i == lkvt_pkg::CMD_REMOVE) begin
            state_d = S_SCAN;
          end else begin
            ctl_o.st_set = 1'b1;
            ctl_o.st_val = lkvt_pkg::STAT_OK;
            state_d      = S_DONE;
          end
        end
      end
      S_SCAN: begin
        ctl_o.scan_en = 1'b1;
        if (stat_i.match) begin
          ctl_o.hit_cap = 1'b1;
          case (stat_i.cmd)
            lkvt_pkg::CMD_INSERT: begin
              ctl_o.st_set = 1'b1;
              ctl_o.st_val = lkvt_pkg::STAT_DUPLICATE;
              state_d      = S_DONE;
            end
            lkvt_pkg::CMD_LOOKUP: begin
              ctl_o.found_cap = 1'b1;
              ctl_o.st_set    = 1'b1;
              ctl_o.st_val    = lkvt_pkg::STAT_OK;
              state_d         = S_DONE;
            end
            lkvt_pkg::CMD_REMOVE: begin
              ctl_o.found_cap = 1'b1;
              state_d         = S_MV_RD;
            end
            default: state_d = S_DONE;
          endcase
        end else if (stat_i.scan_done) begin
          ctl_o.st_set = 1'b1;
          state_d      = S_DONE;
          if (stat_i.cmd == lkvt_pkg::CMD_INSERT) begin
            if (stat_i.full) begin
              ctl_o.st_val = lkvt_pkg::STAT_FULL;
            end else begin
              ctl_o.wr_ins  = 1'b1;
              ctl_o.cnt_inc = 1'b1;
              ctl_o.st_val  = lkvt_pkg::STAT_OK;
            end
          end else begin
            ctl_o.st_val = lkvt_pkg::STAT_NOT_FOUND;
          end
        end
      end
      S_MV_RD: begin
        ctl_o.rd_last = 1'b1;
        state_d       = S_MV_WR;
      end
      S_MV_WR: begin
        ctl_o.wr_mov  = 1'b1;
        ctl_o.cnt_dec = 1'b1;
        ctl_o.st_set  = 1'b1;
        ctl_o.st_val  = lkvt_pkg::STAT_OK;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: design/linear_key_value_table_unit.sv
// Linear key/value table: one command per item, scan over stored entries.
// A hit ends the scan at its slot, a miss scans all stored entries, and an unused
// command goes straight to the result; a remove hit then moves the last entry into
// the freed slot. An output stall holds the result, and no new item is taken until
// the current result has been loaded into the output register.
// Reset clears the entry count and control only; RAM contents are not cleared.
module linear_key_value_table_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lkvt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lkvt_pkg::out_item_t out_item_o
);

  lkvt_pkg::ctl_t  ctl;
  lkvt_pkg::stat_t stat;

  lkvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_item_i.command),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  lkvt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_i       (ctl),
    .stat_o      (stat)
  );

endmodule

FILE: sim/lkvt_table_checker.sv
// Checker for linear_key_value_table_unit: keeps its own copy of the table,
// predicts the reply to each accepted command and compares accepted replies.
// Depends on lkvt_pkg for sizes, codes and item types.
module lkvt_table_checker
  import lkvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  key_t        model_keys [ENTRIES];
  val_t        model_vals [ENTRIES];
  int unsigned model_fill = 0;
  int          fails      = 0;
  out_item_t   replies_due [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic out_item_t table_apply(in_item_t it);
    out_item_t rsp;
    int        hit;
    rsp = '0;
    hit = -1;
    for (int i = 0; i < model_fill; i++) begin
      if (hit < 0 && model_keys[i] == it.key) hit = i;
    end
    case (it.command)
      CMD_INSERT: begin
        if (hit >= 0) begin
          rsp.status = STAT_DUPLICATE;
        end else if (model_fill >= ENTRIES) begin
          rsp.status = STAT_FULL;
        end else begin
          model_keys[model_fill] = it.key;
          model_vals[model_fill] = it.value;
          model_fill++;
        end
      end
      CMD_LOOKUP: begin
        if (hit >= 0) rsp.found_value = model_vals[hit];
        else rsp.status = STAT_NOT_FOUND;
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          rsp.found_value = model_vals[hit];
          model_fill--;
          model_keys[hit] = model_keys[model_fill];
          model_vals[hit] = model_vals[model_fill];
        end else begin
          rsp.status = STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
    rsp.entry_count = model_fill[4:0];
    return rsp;
  endfunction

  function automatic void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t due;
    if (!rst_ni) begin
      model_fill = 0;
      replies_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected item, expected none, actual %h", $time, out_item_i);
        end else begin
          due = replies_due.pop_front();
          field_check("status", 32'(due.status), 32'(out_item_i.status));
          field_check("found_value", due.found_value, out_item_i.found_value);
          field_check("entry_count", 32'(due.entry_count), 32'(out_item_i.entry_count));
        end
      end
      if (in_valid_i && !in_stall_i) replies_due.push_back(table_apply(in_item_i));
    end
    fail_count_o <= fails;
    pending_o    <= replies_due.size();
  end

endmodule

FILE: sim/tb_linear_key_value_table_unit.sv
// Testbench top for linear_key_value_table_unit: drives directed and random
// table commands with random gaps and a long output hold, and gives the verdict.
// Depends on lkvt_pkg, the unit and lkvt_table_checker.
module tb_linear_key_value_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lkvt_pkg::*;

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         POOL_SIZE      = 24;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_item_t  in_item     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_item_t out_item;

  bit        send_gaps   = 1'b1;
  logic      recv_gaps   = 1'b1;
  logic      hold_wanted = 1'b0;
  int        idle_cycles = 0;
  int        fail_count;
  int        pending;
  key_t      key_pool [POOL_SIZE];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  linear_key_value_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  lkvt_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, plus one long hold while the sender keeps offering
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_wanted && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall <= 1'b0;
      end else begin
        out_stall <= recv_gaps && ($urandom_range(99) < 36);
      end
    end
  end

  task automatic offer(logic [1:0] cmd, key_t k, val_t v);
    while (send_gaps && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{command: cmd, key: k, value: v};
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic random_items(int n, int insert_pct);
    logic [1:0] cmd;
    key_t       k;
    int         r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < insert_pct) cmd = CMD_INSERT;
      else if (r < 95) cmd = (r % 2) ? CMD_LOOKUP : CMD_REMOVE;
      else cmd = CMD_UNUSED;
      k = ($urandom_range(9) == 0) ? key_t'($urandom) : key_pool[$urandom_range(POOL_SIZE - 1)];
      offer(cmd, k, val_t'($urandom));
    end
  endtask

  initial begin : stimulus
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = key_t'($urandom);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, extremes, duplicate, unused code, remove of slot 0
    offer(CMD_LOOKUP, '0, 32'h1234_5678);
    offer(CMD_REMOVE, '1, '0);
    offer(CMD_INSERT, '0, '0);
    offer(CMD_INSERT, '1, '1);
    offer(CMD_INSERT, '0, 32'hA5A5_A5A5);
    offer(CMD_LOOKUP, '1, '0);
    offer(CMD_LOOKUP, '0, '1);
    offer(CMD_UNUSED, '1, '1);
    offer(CMD_REMOVE, '0, '0);
    offer(CMD_LOOKUP, '0, '0);
    // fill up, then full and duplicate-when-full
    for (int i = 0; i < 15; i++) offer(CMD_INSERT, key_t'(32'h1 << (2 * i + 1)), val_t'(~i));
    offer(CMD_INSERT, 32'h5555_5555, 32'h0F0F_0F0F);
    offer(CMD_INSERT, '1, 32'h3C3C_3C3C);
    offer(CMD_REMOVE, '1, '0);
    offer(CMD_LOOKUP, key_t'(32'h1 << 29), '0);

    send_gaps = 1'b0;
    recv_gaps <= 1'b0;
    random_items(60, 50);

    hold_wanted <= 1'b1;
    random_items(30, 60);
    hold_wanted <= 1'b0;

    send_gaps = 1'b1;
    recv_gaps <= 1'b1;
    for (int c = 0; c < 6; c++) random_items(50, (c % 2) ? 25 : 70);

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
